### design/power_of_two_radix_to_ascii_macros.svh
// Assertion macros for the power-of-two radix to ASCII converter.
// Included by the top level; no other dependencies.
`ifndef POWER_OF_TWO_RADIX_TO_ASCII_MACROS_SVH
`define POWER_OF_TWO_RADIX_TO_ASCII_MACROS_SVH
`ifndef SYNTHESIS
`define P2RA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define P2RA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define P2RA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define P2RA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/p2ra_pkg.sv
// Shared constants, types and helper functions for the radix to ASCII converter.
// Used by the datapath, the controller and the top level.
package p2ra_pkg;

  localparam int WORD_WIDTH = 32;
  localparam int DIGIT_W    = 5;                    // widest digit, radix 2^5
  localparam int SHIFT_W    = WORD_WIDTH + DIGIT_W - 1;
  localparam int CNT_W      = $clog2(WORD_WIDTH + 1);

  // Digits needed for a full word at each radix exponent.
  localparam int DIG_R1 = WORD_WIDTH;
  localparam int DIG_R2 = (WORD_WIDTH + 1) / 2;
  localparam int DIG_R3 = (WORD_WIDTH + 2) / 3;
  localparam int DIG_R4 = (WORD_WIDTH + 3) / 4;
  localparam int DIG_R5 = (WORD_WIDTH + 4) / 5;

  // Left shift that puts the top digit of the padded word at the top of the shifter.
  localparam int LSH_R1 = SHIFT_W - DIG_R1;
  localparam int LSH_R2 = SHIFT_W - DIG_R2 * 2;
  localparam int LSH_R3 = SHIFT_W - DIG_R3 * 3;
  localparam int LSH_R4 = SHIFT_W - DIG_R4 * 4;
  localparam int LSH_R5 = SHIFT_W - DIG_R5 * 5;

  localparam logic [2:0] RADIX_RESET = 3'd5;
  localparam logic [2:0] RADIX_MIN   = 3'd1;
  localparam logic [2:0] RADIX_MAX   = 3'd5;

  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_A     = 7'h41;
  localparam logic [6:0] ASCII_MINUS = 7'h2D;
  localparam logic [6:0] ASCII_NONE  = 7'h00;
  localparam logic [4:0] DEC_BASE    = 5'd10;

  // Output word source select.
  localparam logic [1:0] SEL_SPECIAL = 2'd0;
  localparam logic [1:0] SEL_SIGN    = 2'd1;
  localparam logic [1:0] SEL_DIGIT   = 2'd2;

  typedef struct packed {
    logic       load;
    logic       advance;
    logic       put;
    logic [1:0] sel;
  } p2ra_cmd_t;

  typedef struct packed {
    logic special;      // zero value or bad radix: one word only
    logic neg;
    logic emit_ok;      // current digit is significant
    logic last_digit;
    logic out_stall;
  } p2ra_sts_t;

  function automatic logic [CNT_W-1:0] max_digits(input logic [2:0] r);
    logic [CNT_W-1:0] n;
    case (r)
      3'd1:    n = CNT_W'(DIG_R1);
      3'd2:    n = CNT_W'(DIG_R2);
      3'd3:    n = CNT_W'(DIG_R3);
      3'd4:    n = CNT_W'(DIG_R4);
      default: n = CNT_W'(DIG_R5);
    endcase
    return n;
  endfunction

  function automatic logic [2:0] align_shift(input logic [2:0] r);
    logic [2:0] s;
    case (r)
      3'd1:    s = 3'(LSH_R1);
      3'd2:    s = 3'(LSH_R2);
      3'd3:    s = 3'(LSH_R3);
      3'd4:    s = 3'(LSH_R4);
      default: s = 3'(LSH_R5);
    endcase
    return s;
  endfunction

  function automatic logic [6:0] digit_ascii(input logic [DIGIT_W-1:0] d);
    logic [6:0] c;
    if (d < DEC_BASE) begin
      c = ASCII_ZERO + 7'(d);
    end else begin
      c = ASCII_A + 7'(d) - 7'(DEC_BASE);
    end
    return c;
  endfunction

endpackage

### design/power_of_two_radix_to_ascii.sv
// Top level of the power-of-two radix to ASCII converter.
// Instantiates p2ra_ctrl and p2ra_datapath; uses p2ra_pkg and the assertion macros.
//
// Usage:
//   Input channel (in_valid/in_ready/in_value) takes one signed 32-bit word.
//   Output channel (out_valid/out_ready) returns its text in base 2^r, one
//   character per word, most significant first: '-' for a negative value,
//   then digits '0'-'9','A'-'V' with leading zeros dropped. out_last_char
//   marks the final character. A zero value gives '0'; a nonzero value with
//   r outside 1 to 5 gives one word with code 0 and out_bad_radix set.
//   The user writes r through cfg_we/cfg_radix_log2 only while the block is idle;
//   the block does not enforce this. r is sampled when a word is accepted.
// Sequence:
//   An accepted word passes through a sign/special step, then a scan step for
//   each digit position of the full word (32 / 16 / 11 / 8 / 7 for r = 1..5),
//   including suppressed leading zeros. A sign or special word is written in
//   the sign/special step and each digit word in its own scan step; a leading
//   zero digit is consumed in its scan step without writing a word.
// Reset and stall:
//   Synchronous active-low reset empties the output register, returns the
//   sequencer to idle and sets r to 5. While a word waits with out_ready low,
//   the sequencer holds before writing another; no character is dropped.
`include "power_of_two_radix_to_ascii_macros.svh"
module power_of_two_radix_to_ascii (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [p2ra_pkg::WORD_WIDTH-1:0] in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [6:0]                            out_char_code,
  output logic                                  out_last_char,
  output logic                                  out_bad_radix,
  input  logic                                  cfg_we,
  input  logic [2:0]                            cfg_radix_log2
);
  import p2ra_pkg::*;

  p2ra_cmd_t cmd;
  p2ra_sts_t sts;

  p2ra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  p2ra_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cfg_we         (cfg_we),
    .cfg_radix_log2 (cfg_radix_log2),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char),
    .out_bad_radix  (out_bad_radix)
  );

  // A new word is never taken right after one was accepted.
  `P2RA_ASSERT_NEXT(a_no_back_to_back, clk, rst_n, in_valid && in_ready, !in_ready)
  // An error word ends its run and carries no character.
  `P2RA_ASSERT_SAME(a_bad_is_last, clk, rst_n, out_valid && out_bad_radix, out_last_char)
  `P2RA_ASSERT_SAME(a_bad_no_char, clk, rst_n, out_valid && out_bad_radix,
                    out_char_code == ASCII_NONE)
  // Words are only written by the sequencer while it is busy with an item.
  `P2RA_ASSERT_SAME(a_put_not_idle, clk, rst_n, cmd.put, !in_ready)

endmodule

### design/p2ra_datapath.sv
// Datapath: radix register, magnitude shifter, digit counter and output register.
// Depends on p2ra_pkg; driven by p2ra_ctrl through command and status structs.
module p2ra_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [p2ra_pkg::WORD_WIDTH-1:0] in_value,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_radix_log2,
  input  p2ra_pkg::p2ra_cmd_t                 cmd,
  output p2ra_pkg::p2ra_sts_t                 sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [6:0]                          out_char_code,
  output logic                                out_last_char,
  output logic                                out_bad_radix
);
  import p2ra_pkg::*;

  logic [2:0]            radix_r;
  logic [2:0]            r_act_r;
  logic [SHIFT_W-1:0]    sh_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  neg_r, special_r, bad_r, started_r;
  logic                  out_valid_r, last_r, badout_r;
  logic [6:0]            char_r;

  logic [WORD_WIDTH-1:0] mag;
  logic                  in_zero, in_bad;
  logic [DIGIT_W-1:0]    top_bits, digit;

  always_comb begin
    mag      = in_value[WORD_WIDTH-1] ? (WORD_WIDTH'(0) - WORD_WIDTH'(in_value))
                                      : WORD_WIDTH'(in_value);
    in_zero  = (in_value == '0);
    in_bad   = (radix_r < RADIX_MIN) || (radix_r > RADIX_MAX);
    top_bits = sh_r[SHIFT_W-1 -: DIGIT_W];
    digit    = top_bits >> (3'(DIGIT_W) - r_act_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_we) begin
      radix_r <= cfg_radix_log2;
    end
  end

  // Magnitude is padded on the left so that every digit lands whole at the top.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_act_r   <= radix_r;
      neg_r     <= in_value[WORD_WIDTH-1];
      special_r <= in_zero || in_bad;
      bad_r     <= !in_zero && in_bad;
      sh_r      <= SHIFT_W'(mag) << align_shift(radix_r);
      cnt_r     <= max_digits(radix_r);
      started_r <= 1'b0;
    end else if (cmd.advance) begin
      sh_r      <= sh_r << r_act_r;
      cnt_r     <= cnt_r - CNT_W'(1);
      started_r <= started_r || (digit != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.put) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      case (cmd.sel)
        SEL_SPECIAL: begin
          char_r   <= bad_r ? ASCII_NONE : ASCII_ZERO;
          last_r   <= 1'b1;
          badout_r <= bad_r;
        end
        SEL_SIGN: begin
          char_r   <= ASCII_MINUS;
          last_r   <= 1'b0;
          badout_r <= 1'b0;
        end
        SEL_DIGIT: begin
          char_r   <= digit_ascii(digit);
          last_r   <= (cnt_r == CNT_W'(1));
          badout_r <= 1'b0;
        end
        default: begin
          char_r   <= ASCII_NONE;
          last_r   <= 1'b1;
          badout_r <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    sts.special    = special_r;
    sts.neg        = neg_r;
    sts.emit_ok    = started_r || (digit != '0);
    sts.last_digit = (cnt_r == CNT_W'(1));
    sts.out_stall  = out_valid_r && !out_ready;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;
  assign out_bad_radix = badout_r;

endmodule

### design/p2ra_ctrl.sv
// Controller state machine: sequences load, sign, digit scan and output writes.
// Depends on p2ra_pkg; talks to p2ra_datapath only through command and status.
module p2ra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  p2ra_pkg::p2ra_sts_t sts,
  output p2ra_pkg::p2ra_cmd_t cmd
);
  import p2ra_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_HEAD   = 2'd1;
  localparam logic [1:0] ST_DIGITS = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    cmd.put     = 1'b0;
    cmd.sel     = SEL_DIGIT;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (sts.special) begin
          if (!sts.out_stall) begin
            cmd.put   = 1'b1;
            cmd.sel   = SEL_SPECIAL;
            state_nxt = ST_IDLE;
          end
        end else if (sts.neg) begin
          if (!sts.out_stall) begin
            cmd.put   = 1'b1;
            cmd.sel   = SEL_SIGN;
            state_nxt = ST_DIGITS;
          end
        end else begin
          state_nxt = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        // Leading zero digits are consumed without writing a word.
        if (!sts.out_stall) begin
          cmd.advance = 1'b1;
          cmd.put     = sts.emit_ok;
          if (sts.last_digit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sim/radix_text_checker.sv
`timescale 1ns / 1ps
// Checker for the power-of-two radix to ASCII converter: watches both channels
// and the radix register writes, predicts each character and compares it.
// Depends on p2ra_pkg for the word width and the character and radix constants.
module radix_text_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic signed [p2ra_pkg::WORD_WIDTH-1:0] in_value,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic [6:0]                             out_char_code,
  input  logic                                   out_last_char,
  input  logic                                   out_bad_radix,
  input  logic                                   cfg_we,
  input  logic [2:0]                             cfg_radix_log2,
  output int                                     fail_count,
  output int                                     pending_chars
);
  import p2ra_pkg::*;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
    logic       bad;
  } text_char_t;

  text_char_t expected_text[$];
  logic [2:0] radix_now;
  text_char_t want;

  initial begin
    fail_count    = 0;
    pending_chars = 0;
    radix_now     = RADIX_RESET;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [6:0] ascii_of_digit(input logic [4:0] d);
    if (d < DEC_BASE) begin
      return ASCII_ZERO + 7'(d);
    end
    return ASCII_A + 7'(d - DEC_BASE);
  endfunction

  // Queues the full text of one accepted word under the current radix.
  function automatic void predict_text(input logic signed [WORD_WIDTH-1:0] value);
    logic [WORD_WIDTH-1:0] mag;
    logic [4:0]            digit;
    int                    r;
    int                    nbits;
    int                    ndig;
    int                    i;
    int                    k;
    r = int'(radix_now);
    if (value == 0) begin
      expected_text.push_back('{ASCII_ZERO, 1'b1, 1'b0});
    end else if (radix_now < RADIX_MIN || radix_now > RADIX_MAX) begin
      expected_text.push_back('{ASCII_NONE, 1'b1, 1'b1});
    end else begin
      // The most negative value negates to itself, which read unsigned is 2^31.
      mag = value[WORD_WIDTH-1] ? -value : value;
      if (value[WORD_WIDTH-1]) begin
        expected_text.push_back('{ASCII_MINUS, 1'b0, 1'b0});
      end
      nbits = 0;
      for (i = 0; i < WORD_WIDTH; i++) begin
        if (mag[i]) begin
          nbits = i + 1;
        end
      end
      ndig = (nbits + r - 1) / r;
      for (k = ndig - 1; k >= 0; k--) begin
        digit = 5'((mag >> (k * r)) & ((32'd1 << r) - 32'd1));
        expected_text.push_back('{ascii_of_digit(digit), k == 0, 1'b0});
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      radix_now = RADIX_RESET;
      expected_text.delete();
    end else begin
      if (cfg_we) begin
        radix_now = cfg_radix_log2;
      end
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("word with code %0h arrived with nothing expected",
                                    out_char_code));
        end else begin
          want = expected_text.pop_front();
          if (out_char_code !== want.code) begin
            report_mismatch($sformatf("char_code expected %0h got %0h",
                                      want.code, out_char_code));
          end
          if (out_last_char !== want.last) begin
            report_mismatch($sformatf("last_char expected %0b got %0b",
                                      want.last, out_last_char));
          end
          if (out_bad_radix !== want.bad) begin
            report_mismatch($sformatf("bad_radix expected %0b got %0b",
                                      want.bad, out_bad_radix));
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_text(in_value);
      end
    end
    pending_chars <= expected_text.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the power-of-two radix to ASCII converter: drives
// values and radix settings, stalls the output side and gives the verdict.
// Depends on p2ra_pkg, the converter RTL and radix_text_checker.
module tb;
  import p2ra_pkg::*;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         in_valid       = 1'b0;
  logic                         in_ready;
  logic signed [WORD_WIDTH-1:0] in_value       = '0;
  logic                         out_valid;
  logic                         out_ready      = 1'b0;
  logic [6:0]                   out_char_code;
  logic                         out_last_char;
  logic                         out_bad_radix;
  logic                         cfg_we         = 1'b0;
  logic [2:0]                   cfg_radix_log2 = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count;
  int pending_chars;
  int phase;
  int setting;
  int n;

  initial begin
    forever #5 clk = ~clk;
  end

  power_of_two_radix_to_ascii dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char),
    .out_bad_radix  (out_bad_radix),
    .cfg_we         (cfg_we),
    .cfg_radix_log2 (cfg_radix_log2)
  );

  radix_text_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char),
    .out_bad_radix  (out_bad_radix),
    .cfg_we         (cfg_we),
    .cfg_radix_log2 (cfg_radix_log2),
    .fail_count     (fail_count),
    .pending_chars  (pending_chars)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Leaves valid high after acceptance so back-to-back words need no toggle.
  task automatic send_word(input logic signed [WORD_WIDTH-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  // The pending count lags the queue size, so look only after the first edge.
  task automatic drain_text();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_chars != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_radix(input logic [2:0] r);
    drain_text();
    cfg_we         <= 1'b1;
    cfg_radix_log2 <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [WORD_WIDTH-1:0] random_value();
    logic [WORD_WIDTH-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = $urandom_range(1) ? {1'b1, {(WORD_WIDTH-1){1'b0}}}
                               : {1'b0, {(WORD_WIDTH-1){1'b1}}};
      2, 3, 4, 5: v = $urandom;
      default: begin
        // Short magnitudes so the digit count varies widely.
        v = $urandom >> $urandom_range(WORD_WIDTH - 1);
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  function automatic logic [2:0] random_radix();
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(2))
        0:       return 3'd0;
        1:       return 3'd6;
        default: return 3'd7;
      endcase
    end
    return 3'($urandom_range(RADIX_MAX, RADIX_MIN));
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset radix of 32: zero, digit and letter boundaries, signs, extremes.
    send_word(0);
    send_word(1);
    send_word(9);
    send_word(10);
    send_word(31);
    send_word(32);
    send_word(-1);
    send_word(32'sh7FFF_FFFF);
    send_word(32'sh8000_0000);

    // Binary gives the longest runs, the most negative value the longest of all.
    set_radix(RADIX_MIN);
    send_word(32'sh8000_0000);
    send_word(32'sh7FFF_FFFF);
    send_word(1);

    // Out-of-range radix: zero still converts, anything else flags an error.
    set_radix(3'd0);
    send_word(0);
    send_word(5);
    set_radix(3'd6);
    send_word(-7);
    set_radix(3'd7);
    send_word(0);
    send_word(32'sh8000_0000);

    set_radix(3'd2);
    send_word(-3);
    set_radix(3'd3);
    send_word(8);
    set_radix(3'd4);
    send_word(-32'sh1234_5678);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (setting = 0; setting < 3; setting++) begin
        if (setting == 0) begin
          set_radix((phase % 2) ? RADIX_MAX : RADIX_MIN);
        end else begin
          set_radix(random_radix());
        end
        for (n = 0; n < 9; n++) begin
          send_word(random_value());
        end
      end
    end

    drain_text();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### power_of_two_radix_to_ascii.f
+incdir+design
design/p2ra_pkg.sv
design/p2ra_datapath.sv
design/p2ra_ctrl.sv
design/power_of_two_radix_to_ascii.sv
sim/radix_text_checker.sv
sim/tb.sv
